// ===== design/circle_polygon_overlap_unit_assert.svh =====
// Assertion macros for the circle/polygon overlap unit.
// Depends on: signals clock and reset in the including module.
`ifndef CIRCLE_POLYGON_OVERLAP_UNIT_ASSERT_SVH
`define CIRCLE_POLYGON_OVERLAP_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CPO_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define CPO_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== design/cpo_pkg.sv =====
// Shared types and constants for the circle/polygon overlap unit.
// Depends on: nothing.
package cpo_pkg;

   localparam int RADIUS_BITS = 15;
   localparam int NUM_VERTS   = 4;
   localparam int NUM_SEGS    = 5;
   localparam int NUM_STAGES  = 6;

   // Operation codes
   typedef enum logic [1:0] {
      OP_SEGMENT  = 2'd0,
      OP_TRIANGLE = 2'd1,
      OP_QUAD     = 2'd2
   } cpo_op_type;

   // Segment endpoints: p1p2, p2p3, p3p4, p4p1, diagonal p1p3
   localparam int SEG_U [NUM_SEGS] = '{0, 1, 2, 3, 0};
   localparam int SEG_V [NUM_SEGS] = '{1, 2, 3, 0, 2};

   // Load enables for the stages held inside a segment unit
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
      logic s5;
   } cpo_en_type;

   // Segment unit result: hit flag and sign of cross(A,B)
   typedef struct packed {
      logic hit;
      logic xneg;
      logic xzero;
   } cpo_seg_out_type;

endpackage

// ===== design/cpo_seg.sv =====
// One segment test: circle against segment u->v, stages 2 to 5.
// Depends on: cpo_pkg.
module cpo_seg #(
   parameter int COORD_BITS = 16
) (
   input  logic                                clock,
   input  cpo_pkg::cpo_en_type                 en,
   input  logic signed [COORD_BITS:0]          ax,
   input  logic signed [COORD_BITS:0]          ay,
   input  logic signed [COORD_BITS:0]          bx,
   input  logic signed [COORD_BITS:0]          by,
   input  logic signed [COORD_BITS:0]          qx,
   input  logic signed [COORD_BITS:0]          qy,
   input  logic [cpo_pkg::RADIUS_BITS-1:0]     radius,
   output cpo_pkg::cpo_seg_out_type            result
);

   localparam int D  = COORD_BITS + 1;
   localparam int P  = 2 * D + 1;
   localparam int M  = 2 * D;
   localparam int RB = 2 * cpo_pkg::RADIUS_BITS;
   localparam int LW = (M > RB) ? M : RB;
   localparam int QW = 4 * D;
   localparam int RW = RB + M;
   localparam int HW = RB + D;
   localparam int CW = (QW > RW) ? QW : RW;

   // Stage 2: dot, cross and squared lengths
   logic signed [P-1:0] la_w, lc_w, lb_w, d1_w, d2_w, x_w;
   logic [M-1:0]        la_ff, lc_ff, lb_ff;
   logic signed [P-1:0] d1_ff, d2_ff, x_ff;
   logic                zero_ff;
   logic [RB-1:0]       r2_ff;

   assign la_w = P'(ax) * P'(ax) + P'(ay) * P'(ay);
   assign lc_w = P'(qx) * P'(qx) + P'(qy) * P'(qy);
   assign lb_w = P'(bx) * P'(bx) + P'(by) * P'(by);
   assign d1_w = P'(ax) * P'(bx) + P'(ay) * P'(by);
   assign d2_w = P'(bx) * P'(qx) + P'(by) * P'(qy);
   assign x_w  = P'(ax) * P'(by) - P'(ay) * P'(bx);

   always_ff @(posedge clock) begin
      if (en.s2) begin
         la_ff   <= la_w[M-1:0];
         lc_ff   <= lc_w[M-1:0];
         lb_ff   <= lb_w[M-1:0];
         d1_ff   <= d1_w;
         d2_ff   <= d2_w;
         x_ff    <= x_w;
         zero_ff <= (bx == '0) && (by == '0);
         r2_ff   <= RB'(radius) * RB'(radius);
      end
   end

   // Stage 3: projection side, endpoint compares, cross magnitude
   logic         between3_ff, zero3_ff, ea3_ff, ec3_ff, xneg3_ff, xzero3_ff;
   logic [M-1:0] mag3_ff, lb3_ff;
   logic [RB-1:0] r23_ff;
   logic signed [P-1:0] xneg_w;

   assign xneg_w = -x_ff;

   always_ff @(posedge clock) begin
      if (en.s3) begin
         between3_ff <= (d1_ff == '0) || (d2_ff == '0) || (d1_ff[P-1] != d2_ff[P-1]);
         zero3_ff    <= zero_ff;
         ea3_ff      <= LW'(la_ff) <= LW'(r2_ff);
         ec3_ff      <= LW'(lc_ff) <= LW'(r2_ff);
         xneg3_ff    <= x_ff[P-1];
         xzero3_ff   <= x_ff == '0;
         mag3_ff     <= x_ff[P-1] ? xneg_w[M-1:0] : x_ff[M-1:0];
         lb3_ff      <= lb_ff;
         r23_ff      <= r2_ff;
      end
   end

   // Stage 4: partial products of cross^2 and r^2 * |B|^2
   logic [M-1:0]  hh4_ff, hl4_ff, ll4_ff;
   logic [HW-1:0] rh4_ff, rl4_ff;
   logic          between4_ff, zero4_ff, ea4_ff, ec4_ff, xneg4_ff, xzero4_ff;

   always_ff @(posedge clock) begin
      if (en.s4) begin
         hh4_ff      <= M'(mag3_ff[M-1:D]) * M'(mag3_ff[M-1:D]);
         hl4_ff      <= M'(mag3_ff[M-1:D]) * M'(mag3_ff[D-1:0]);
         ll4_ff      <= M'(mag3_ff[D-1:0]) * M'(mag3_ff[D-1:0]);
         rh4_ff      <= HW'(r23_ff) * HW'(lb3_ff[M-1:D]);
         rl4_ff      <= HW'(r23_ff) * HW'(lb3_ff[D-1:0]);
         between4_ff <= between3_ff;
         zero4_ff    <= zero3_ff;
         ea4_ff      <= ea3_ff;
         ec4_ff      <= ec3_ff;
         xneg4_ff    <= xneg3_ff;
         xzero4_ff   <= xzero3_ff;
      end
   end

   // Stage 5: sum partial products, distance compare, edge verdict
   logic [CW-1:0] cr2_w, rlb_w;
   logic          near_w;
   cpo_pkg::cpo_seg_out_type result_ff;

   assign cr2_w  = (CW'(hh4_ff) << M) + (CW'(hl4_ff) << (D + 1)) + CW'(ll4_ff);
   assign rlb_w  = (CW'(rh4_ff) << D) + CW'(rl4_ff);
   assign near_w = cr2_w <= rlb_w;

   always_ff @(posedge clock) begin
      if (en.s5) begin
         result_ff.hit   <= zero4_ff ? ea4_ff :
                            (between4_ff ? near_w : (ea4_ff | ec4_ff));
         result_ff.xneg  <= xneg4_ff;
         result_ff.xzero <= xzero4_ff;
      end
   end

   assign result = result_ff;

endmodule

// ===== design/circle_polygon_overlap_unit.sv =====
// Circle against segment, triangle or quad overlap test, top level.
// Depends on: cpo_pkg, cpo_seg, circle_polygon_overlap_unit_assert.svh.
//
// Usage:
//   req_* carries one word per test: operation, circle center and radius,
//   and four vertices. rsp_hit returns 1 when the circle touches or
//   overlaps the selected shape (segment p1p2, triangle p1p2p3, quad
//   p1..p4); the unused operation code gives 0.
//   Both channels use valid/ready; a word moves when both are high.
//   Throughput: one word per cycle while rsp_ready stays high, through the
//   six register stages (differences, products, compares, partial
//   products of the wide squares, wide sum and compare, shape select).
//   Five segment units run in parallel: the four sides and the diagonal.
//   When rsp_ready is low, the output word holds; earlier stages keep
//   filling empty slots, so req_ready drops only when all six stages
//   hold a word.
//   Reset (synchronous, active high) empties the pipeline; no word is
//   lost or repeated under stalls.
module circle_polygon_overlap_unit #(
   parameter int COORD_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic signed [COORD_BITS-1:0]      req_center_x,
   input  logic signed [COORD_BITS-1:0]      req_center_y,
   input  logic [cpo_pkg::RADIUS_BITS-1:0]   req_radius,
   input  logic signed [COORD_BITS-1:0]      req_vertex1_x,
   input  logic signed [COORD_BITS-1:0]      req_vertex1_y,
   input  logic signed [COORD_BITS-1:0]      req_vertex2_x,
   input  logic signed [COORD_BITS-1:0]      req_vertex2_y,
   input  logic signed [COORD_BITS-1:0]      req_vertex3_x,
   input  logic signed [COORD_BITS-1:0]      req_vertex3_y,
   input  logic signed [COORD_BITS-1:0]      req_vertex4_x,
   input  logic signed [COORD_BITS-1:0]      req_vertex4_y,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_hit
);

   `include "circle_polygon_overlap_unit_assert.svh"

   localparam int D  = COORD_BITS + 1;
   localparam int NS = cpo_pkg::NUM_STAGES;
   localparam int NE = cpo_pkg::NUM_SEGS;

   // Stage valids and advance chain
   logic [NS:1] valid_ff, valid_in, adv;

   always_comb begin
      adv[NS] = !valid_ff[NS] || rsp_ready;
      for (int k = NS - 1; k >= 1; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_comb begin
      valid_in[1] = adv[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= NS; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = adv[1];
   assign rsp_valid = valid_ff[NS];

   // Vertex lookup
   logic signed [COORD_BITS-1:0] vx [cpo_pkg::NUM_VERTS];
   logic signed [COORD_BITS-1:0] vy [cpo_pkg::NUM_VERTS];

   assign vx[0] = req_vertex1_x;
   assign vy[0] = req_vertex1_y;
   assign vx[1] = req_vertex2_x;
   assign vy[1] = req_vertex2_y;
   assign vx[2] = req_vertex3_x;
   assign vy[2] = req_vertex3_y;
   assign vx[3] = req_vertex4_x;
   assign vy[3] = req_vertex4_y;

   // Operation travels with the word through stages 1..5
   logic [1:0] op_ff [1:NS-1];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         op_ff[1] <= req_operation;
      end
      for (int k = 2; k < NS; k++) begin
         if (adv[k]) begin
            op_ff[k] <= op_ff[k-1];
         end
      end
   end

   // Stage 1 radius register
   logic [cpo_pkg::RADIUS_BITS-1:0] radius_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         radius_ff <= req_radius;
      end
   end

   cpo_pkg::cpo_en_type      seg_en;
   cpo_pkg::cpo_seg_out_type seg_out [NE];

   assign seg_en.s2 = adv[2];
   assign seg_en.s3 = adv[3];
   assign seg_en.s4 = adv[4];
   assign seg_en.s5 = adv[5];

   // Stage 1: per-segment difference vectors, then the segment units
   for (genvar g = 0; g < NE; g++) begin : g_seg
      localparam int U = cpo_pkg::SEG_U[g];
      localparam int V = cpo_pkg::SEG_V[g];

      logic signed [D-1:0] ax_ff, ay_ff, bx_ff, by_ff, qx_ff, qy_ff;

      always_ff @(posedge clock) begin
         if (adv[1]) begin
            ax_ff <= D'(req_center_x) - D'(vx[U]);
            ay_ff <= D'(req_center_y) - D'(vy[U]);
            bx_ff <= D'(vx[V]) - D'(vx[U]);
            by_ff <= D'(vy[V]) - D'(vy[U]);
            qx_ff <= D'(req_center_x) - D'(vx[V]);
            qy_ff <= D'(req_center_y) - D'(vy[V]);
         end
      end

      cpo_seg #(
         .COORD_BITS(COORD_BITS)
      ) u_seg (
         .clock  (clock),
         .en     (seg_en),
         .ax     (ax_ff),
         .ay     (ay_ff),
         .bx     (bx_ff),
         .by     (by_ff),
         .qx     (qx_ff),
         .qy     (qy_ff),
         .radius (radius_ff),
         .result (seg_out[g])
      );
   end

   // Stage 6: inside tests and shape select
   logic gt0, gt1, gt2, gt3, gt4, lt0, lt2, lt3, lt4, le1, le3;
   logic in_tri1, in_tri2, hit_sel;
   logic rsp_hit_ff;

   assign gt0 = !seg_out[0].xneg && !seg_out[0].xzero;
   assign gt1 = !seg_out[1].xneg && !seg_out[1].xzero;
   assign gt2 = !seg_out[2].xneg && !seg_out[2].xzero;
   assign gt3 = !seg_out[3].xneg && !seg_out[3].xzero;
   assign gt4 = !seg_out[4].xneg && !seg_out[4].xzero;
   assign lt0 = seg_out[0].xneg;
   assign lt2 = seg_out[2].xneg;
   assign lt3 = seg_out[3].xneg;
   assign lt4 = seg_out[4].xneg;
   assign le1 = seg_out[1].xneg || seg_out[1].xzero;
   assign le3 = seg_out[3].xneg || seg_out[3].xzero;

   // triangle p1p2p3 uses sides p2p3, diagonal, p1p2; p3p4p1 uses p4p1, diagonal, p3p4
   assign in_tri1 = (le1 && gt4 && lt0) || (gt1 && lt4 && gt0);
   assign in_tri2 = (le3 && lt4 && lt2) || (gt3 && gt4 && gt2);

   always_comb begin
      unique case (op_ff[NS-1])
         cpo_pkg::OP_SEGMENT:  hit_sel = seg_out[0].hit;
         cpo_pkg::OP_TRIANGLE: hit_sel = seg_out[0].hit || seg_out[4].hit ||
                                         seg_out[1].hit || in_tri1;
         cpo_pkg::OP_QUAD:     hit_sel = seg_out[0].hit || seg_out[1].hit ||
                                         seg_out[2].hit || seg_out[3].hit ||
                                         seg_out[4].hit || in_tri1 || in_tri2;
         default:              hit_sel = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv[NS]) begin
         rsp_hit_ff <= hit_sel;
      end
   end

   assign rsp_hit = rsp_hit_ff;

   // Checks
   `CPO_ASSERT_IMPLY(a_ready_when_slot, !(&valid_ff), req_ready)
   `CPO_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, valid_ff[1])
   `CPO_ASSERT_NEXT(a_segment_select,
      valid_ff[NS-1] && adv[NS] && (op_ff[NS-1] == cpo_pkg::OP_SEGMENT),
      rsp_hit == $past(seg_out[0].hit))

endmodule
